// ===== design/rba_pkg.sv =====
// ----------------------------------------------------------------------------
// rba_pkg
// Types, constants and fixed-point helpers for the angular acceleration block.
// ----------------------------------------------------------------------------
package rba_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QW        = 32;
    localparam int PW        = 2 * QW;
    localparam int SW        = PW - FRAC_BITS + 2;
    localparam int NW        = QW + FRAC_BITS;
    localparam int RW        = PW;

    typedef logic signed [QW-1:0] t_q;
    typedef logic signed [SW-1:0] t_s;

    localparam t_q Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam t_q Q_MIN = {1'b1, {(QW-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_XX = 3'd0,
        REG_YY = 3'd1,
        REG_ZZ = 3'd2,
        REG_XY = 3'd3,
        REG_XZ = 3'd4,
        REG_YZ = 3'd5
    } t_reg;

    typedef struct packed {
        t_q rate_x;
        t_q rate_y;
        t_q rate_z;
        t_q torque_x;
        t_q torque_y;
        t_q torque_z;
    } t_in;

    typedef struct packed {
        t_q   accel_x;
        t_q   accel_y;
        t_q   accel_z;
        logic singular;
    } t_out;

    typedef struct packed {
        t_q xx;
        t_q yy;
        t_q zz;
        t_q xy;
        t_q xz;
        t_q yz;
    } t_ten;

    typedef struct packed {
        t_q c00;
        t_q c01;
        t_q c02;
        t_q c11;
        t_q c12;
        t_q c22;
        t_q det;
    } t_cof;

    function automatic t_s fmul(input t_q a, input t_q b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b);
        return SW'(p >>> FRAC_BITS);
    endfunction

    function automatic t_q sat(input t_s v);
        priority if (v > SW'(Q_MAX)) begin
            return Q_MAX;
        end else if (v < SW'(Q_MIN)) begin
            return Q_MIN;
        end else begin
            return QW'(v);
        end
    endfunction

endpackage

// ===== design/rigid_body_angular_acceleration.sv =====
// ----------------------------------------------------------------------------
// rigid_body_angular_acceleration
// Euler rotation equation: alpha = inv(I) * (M - w x (I*w)), Q16.16.
// ----------------------------------------------------------------------------
// One item is taken in every cycle (o_busy stays low) and its result appears
// on o_result with o_done high for one cycle, through 41 register stages, the
// first loaded at the edge that took the item: seven stages for the momentum,
// cross product, residual moment and adjugate product, then one set-up stage,
// one stage for each of the 32 quotient bits of the divider and one saturation
// stage. The receiver cannot stall the block. The inertia cofactors follow a
// write through the product and cofactor registers, the determinant through
// those, r_dp and r_det; write the tensor only while no item is in flight.
module rigid_body_angular_acceleration
    import rba_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  t_in        i_item,
    output logic       o_done,
    output t_out       o_result,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  t_q         i_cfg_data
);

    t_ten ten;
    t_cof cof;
    logic nv;
    t_q   nx, ny, nz;
    logic vx, vy, vz;
    logic sx, sy, sz;
    t_q   qx, qy, qz;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    rba_cofactor u_cof (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ten       (ten),
        .o_cof       (cof)
    );

    rba_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_item  (i_item),
        .i_ten   (ten),
        .i_cof   (cof),
        .o_valid (nv),
        .o_nx    (nx),
        .o_ny    (ny),
        .o_nz    (nz)
    );

    rba_div u_div_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (nv), .i_n (nx),
        .i_det (cof.det), .o_valid (vx), .o_q (qx), .o_sing (sx)
    );

    rba_div u_div_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (nv), .i_n (ny),
        .i_det (cof.det), .o_valid (vy), .o_q (qy), .o_sing (sy)
    );

    rba_div u_div_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (nv), .i_n (nz),
        .i_det (cof.det), .o_valid (vz), .o_q (qz), .o_sing (sz)
    );

    assign o_done            = vx && vy && vz;
    assign o_result.accel_x  = qx;
    assign o_result.accel_y  = qy;
    assign o_result.accel_z  = qz;
    assign o_result.singular = sx && sy && sz;

endmodule

// ===== design/rba_cofactor.sv =====
// ----------------------------------------------------------------------------
// rba_cofactor
// Inertia registers, adjugate cofactors and determinant.
// ----------------------------------------------------------------------------
module rba_cofactor
    import rba_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic [2:0] i_cfg_index,
    input  t_q         i_cfg_data,
    output t_ten       o_ten,
    output t_cof       o_cof
);

    logic [QW-2:0] r_xx, r_yy, r_zz;
    t_q            r_xy, r_xz, r_yz;
    t_q            a, b, c;
    t_s            r_p [12];
    t_cof          r_cof;
    t_s            r_dp [3];
    t_q            r_det;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xx <= (QW-1)'(1) << FRAC_BITS;
            r_yy <= (QW-1)'(1) << FRAC_BITS;
            r_zz <= (QW-1)'(1) << FRAC_BITS;
            r_xy <= '0;
            r_xz <= '0;
            r_yz <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg'(i_cfg_index))
                REG_XX:  r_xx <= i_cfg_data[QW-2:0];
                REG_YY:  r_yy <= i_cfg_data[QW-2:0];
                REG_ZZ:  r_zz <= i_cfg_data[QW-2:0];
                REG_XY:  r_xy <= i_cfg_data;
                REG_XZ:  r_xz <= i_cfg_data;
                REG_YZ:  r_yz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign a = {1'b0, r_xx};
    assign b = {1'b0, r_yy};
    assign c = {1'b0, r_zz};

    assign o_ten = '{a, b, c, r_xy, r_xz, r_yz};

    always_ff @(posedge i_clk) begin
        r_p[0]  <= fmul(b, c);
        r_p[1]  <= fmul(r_yz, r_yz);
        r_p[2]  <= fmul(r_xz, r_yz);
        r_p[3]  <= fmul(r_xy, c);
        r_p[4]  <= fmul(r_xy, r_yz);
        r_p[5]  <= fmul(b, r_xz);
        r_p[6]  <= fmul(a, c);
        r_p[7]  <= fmul(r_xz, r_xz);
        r_p[8]  <= fmul(r_xy, r_xz);
        r_p[9]  <= fmul(a, r_yz);
        r_p[10] <= fmul(a, b);
        r_p[11] <= fmul(r_xy, r_xy);
        r_cof.c00 <= sat(r_p[0] - r_p[1]);
        r_cof.c01 <= sat(r_p[2] - r_p[3]);
        r_cof.c02 <= sat(r_p[4] - r_p[5]);
        r_cof.c11 <= sat(r_p[6] - r_p[7]);
        r_cof.c12 <= sat(r_p[8] - r_p[9]);
        r_cof.c22 <= sat(r_p[10] - r_p[11]);
        r_cof.det <= r_det;
        r_dp[0] <= fmul(a, r_cof.c00);
        r_dp[1] <= fmul(r_xy, r_cof.c01);
        r_dp[2] <= fmul(r_xz, r_cof.c02);
        r_det   <= sat(r_dp[0] + r_dp[1] + r_dp[2]);
    end

    always_comb begin
        o_cof     = r_cof;
        o_cof.det = r_det;
    end

endmodule

// ===== design/rba_front.sv =====
// ----------------------------------------------------------------------------
// rba_front
// Momentum, gyroscopic term, residual moment and adjugate product.
// ----------------------------------------------------------------------------
module rba_front
    import rba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_item,
    input  t_ten i_ten,
    input  t_cof i_cof,
    output logic o_valid,
    output t_q   o_nx,
    output t_q   o_ny,
    output t_q   o_nz
);

    logic [6:0] r_v;
    t_s   r_lp [9];
    t_s   r_kp [6];
    t_s   r_np [9];
    t_in  r_i1, r_i2, r_i3;
    t_q   r_m4x, r_m4y, r_m4z;
    t_q   r_lx, r_ly, r_lz;
    t_q   r_kx, r_ky, r_kz;
    t_q   r_ex, r_ey, r_ez;
    t_q   r_nx, r_ny, r_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1    <= i_item;
        r_lp[0] <= fmul(i_ten.xx, i_item.rate_x);
        r_lp[1] <= fmul(i_ten.xy, i_item.rate_y);
        r_lp[2] <= fmul(i_ten.xz, i_item.rate_z);
        r_lp[3] <= fmul(i_ten.xy, i_item.rate_x);
        r_lp[4] <= fmul(i_ten.yy, i_item.rate_y);
        r_lp[5] <= fmul(i_ten.yz, i_item.rate_z);
        r_lp[6] <= fmul(i_ten.xz, i_item.rate_x);
        r_lp[7] <= fmul(i_ten.yz, i_item.rate_y);
        r_lp[8] <= fmul(i_ten.zz, i_item.rate_z);

        r_i2 <= r_i1;
        r_lx <= sat(r_lp[0] + r_lp[1] + r_lp[2]);
        r_ly <= sat(r_lp[3] + r_lp[4] + r_lp[5]);
        r_lz <= sat(r_lp[6] + r_lp[7] + r_lp[8]);

        r_i3    <= r_i2;
        r_kp[0] <= fmul(r_i2.rate_y, r_lz);
        r_kp[1] <= fmul(r_i2.rate_z, r_ly);
        r_kp[2] <= fmul(r_i2.rate_z, r_lx);
        r_kp[3] <= fmul(r_i2.rate_x, r_lz);
        r_kp[4] <= fmul(r_i2.rate_x, r_ly);
        r_kp[5] <= fmul(r_i2.rate_y, r_lx);

        r_m4x <= r_i3.torque_x;
        r_m4y <= r_i3.torque_y;
        r_m4z <= r_i3.torque_z;
        r_kx  <= sat(r_kp[0] - r_kp[1]);
        r_ky  <= sat(r_kp[2] - r_kp[3]);
        r_kz  <= sat(r_kp[4] - r_kp[5]);

        r_ex <= sat(SW'(r_m4x) - SW'(r_kx));
        r_ey <= sat(SW'(r_m4y) - SW'(r_ky));
        r_ez <= sat(SW'(r_m4z) - SW'(r_kz));

        r_np[0] <= fmul(i_cof.c00, r_ex);
        r_np[1] <= fmul(i_cof.c01, r_ey);
        r_np[2] <= fmul(i_cof.c02, r_ez);
        r_np[3] <= fmul(i_cof.c01, r_ex);
        r_np[4] <= fmul(i_cof.c11, r_ey);
        r_np[5] <= fmul(i_cof.c12, r_ez);
        r_np[6] <= fmul(i_cof.c02, r_ex);
        r_np[7] <= fmul(i_cof.c12, r_ey);
        r_np[8] <= fmul(i_cof.c22, r_ez);

        r_nx <= sat(r_np[0] + r_np[1] + r_np[2]);
        r_ny <= sat(r_np[3] + r_np[4] + r_np[5]);
        r_nz <= sat(r_np[6] + r_np[7] + r_np[8]);
    end

    assign o_valid = r_v[6];
    assign o_nx    = r_nx;
    assign o_ny    = r_ny;
    assign o_nz    = r_nz;

endmodule

// ===== design/rba_div.sv =====
// ----------------------------------------------------------------------------
// rba_div
// Pipelined restoring divider: one quotient bit per stage, saturated result.
// ----------------------------------------------------------------------------
module rba_div
    import rba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_q   i_n,
    input  t_q   i_det,
    output logic o_valid,
    output t_q   o_q,
    output logic o_sing
);

    logic [QW-1:0]   mag_n, mag_d;
    logic [NW-1:0]   num;
    logic            r_v    [QW+1];
    logic [RW-1:0]   r_rem  [QW+1];
    logic [QW-1:0]   r_quo  [QW+1];
    logic [QW-1:0]   r_d    [QW+1];
    logic            r_neg  [QW+1];
    logic            r_ovf  [QW+1];
    logic            r_sg   [QW+1];
    logic            r_ov;
    logic            r_ovo;
    t_q              r_q;
    logic            r_so;

    assign mag_n = i_n[QW-1]   ? QW'(-i_n)   : QW'(i_n);
    assign mag_d = i_det[QW-1] ? QW'(-i_det) : QW'(i_det);
    assign num   = {mag_n, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= RW'(num);
        r_quo[0] <= '0;
        r_d[0]   <= mag_d;
        r_neg[0] <= i_n[QW-1] ^ i_det[QW-1];
        r_sg[0]  <= (i_det == '0);
        r_ovf[0] <= (RW'(num) >> QW) >= RW'(mag_d);
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int BIT = QW - 1 - k;
        logic [RW-1:0] dsh;
        logic          take;
        assign dsh  = RW'(r_d[k]) << BIT;
        assign take = r_rem[k] >= dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= take ? r_rem[k] - dsh : r_rem[k];
            r_quo[k+1] <= r_quo[k] | (QW'(take) << BIT);
            r_d[k+1]   <= r_d[k];
            r_neg[k+1] <= r_neg[k];
            r_ovf[k+1] <= r_ovf[k];
            r_sg[k+1]  <= r_sg[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_so  <= r_sg[QW];
        r_ovo <= r_ovf[QW] && !r_sg[QW];
        priority if (r_sg[QW]) begin
            r_q <= '0;
        end else if (r_neg[QW]) begin
            if (r_ovf[QW] || r_quo[QW] > QW'(Q_MIN)) begin
                r_q <= Q_MIN;
            end else begin
                r_q <= QW'(-r_quo[QW]);
            end
        end else begin
            if (r_ovf[QW] || r_quo[QW][QW-1]) begin
                r_q <= Q_MAX;
            end else begin
                r_q <= r_quo[QW];
            end
        end
    end

    assign o_valid = r_ov;
    assign o_q     = r_q;
    assign o_sing  = r_so;

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_so |-> r_q == '0)
        else $error("singular item with non-zero acceleration");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] && !r_ovf[0] && !r_sg[0] |-> r_rem[0] < (RW'(r_d[0]) << QW))
        else $error("divider remainder out of range");

    a_ovf_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_ovo |-> (r_q == Q_MAX || r_q == Q_MIN))
        else $error("overflowed quotient not saturated");

endmodule
